// ----- hdl/dcta_pkg.sv -----
package dcta_pkg;

   // Frame geometry.
   localparam int COLUMNS = 6;
   localparam int ROWS    = 4;

   // Field and register widths.
   localparam int DIST_W = 16;
   localparam int TILT_W = 15;
   localparam int NEAR_W = 16;
   localparam int DEG_W  = 16;
   localparam int TRIG_W = 16;

   // Accumulator and index widths follow from the row and column counts.
   localparam int HIT_W = $clog2(ROWS + 1);
   localparam int ROW_W = $clog2(ROWS + 1);
   localparam int SUM_W = DIST_W - 1 + HIT_W;
   localparam int THR_W = NEAR_W + HIT_W;
   localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ACC_W = TRIG_W + $clog2(COLUMNS + 1);

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 24;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Tilt limit scaled from Q1.15 to Q2.30.
   localparam int LIM_SHIFT = 15;

   // Radians to degrees: 180/pi in Q16, result taken from Q2.30 * Q16 to Q7.8.
   localparam logic signed [MUL_B_W-1:0] RAD2DEG = MUL_B_W'(3754936);
   localparam int DEG_SHIFT = 38;
   localparam logic signed [MUL_P_W-1:0] DEG_HALF = MUL_P_W'(64'd1 << (DEG_SHIFT - 1));

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_TILT = 1'b0;
   localparam logic REG_NEAR = 1'b1;

   // Column direction table: cosine and sine in Q1.15.
   localparam logic signed [TRIG_W-1:0] ROM_COS [COLUMNS] = '{
      16'sd31299, 16'sd24056, -16'sd7234, -16'sd31293, -16'sd24069, 16'sd7215
   };
   localparam logic signed [TRIG_W-1:0] ROM_SIN [COLUMNS] = '{
      16'sd9702, -16'sd22250, -16'sd31959, -16'sd9721, 16'sd22235, 16'sd31964
   };

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_PMUL,
      S_PDEG,
      S_RMUL,
      S_RDEG,
      S_ROUND,
      S_OUT
   } dcta_state_type;

   // Operand selection for the shared multiplier.
   typedef enum logic [1:0] {
      M_COS,
      M_SIN,
      M_DEG
   } dcta_msel_type;

endpackage

// ----- hdl/dcta_ifs.sv -----
// Depth sample channel.
interface dcta_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [dcta_pkg::DIST_W-1:0] distance;
   logic                              last;

   modport source (output valid, output distance, output last, input ready);
   modport sink (input valid, input distance, input last, output ready);
endinterface

// Tilt reference channel.
interface dcta_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [dcta_pkg::DEG_W-1:0] pitch_deg;
   logic signed [dcta_pkg::DEG_W-1:0] roll_deg;

   modport source (output valid, output pitch_deg, output roll_deg, input ready);
   modport sink (input valid, input pitch_deg, input roll_deg, output ready);
endinterface

// ----- hdl/dcta_mul.sv -----
module dcta_mul (
   input  logic                                clock,
   input  logic signed [dcta_pkg::MUL_A_W-1:0] op_a,
   input  logic signed [dcta_pkg::MUL_B_W-1:0] op_b,
   output logic signed [dcta_pkg::MUL_P_W-1:0] prod
);

   logic signed [dcta_pkg::MUL_P_W-1:0] prod_ff;
   logic signed [dcta_pkg::MUL_P_W-1:0] prod_in;

   // Full signed product, registered before anyone uses it.
   assign prod_in = dcta_pkg::MUL_P_W'(op_a) * dcta_pkg::MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- hdl/depth_column_tilt_avoider.sv -----
// A sample without the frame-end mark is taken as soon as it is offered. After the
// frame's last sample is accepted, the block scans the columns, one per cycle, then
// makes four passes through the shared multiplier and one rounding step before the
// result is valid; input is held off until the result is taken.
// Throughput: one sample per cycle within a frame.
// Reset: synchronous; clears all column sums, counts and position, loads the
// default tilt limit and near threshold, and leaves the block ready for samples.
module depth_column_tilt_avoider (
   input  logic                                  clock,
   input  logic                                  reset,
   dcta_req_if.sink                              req_chan,
   dcta_rsp_if.source                            rsp_chan,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [dcta_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [dcta_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [dcta_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   // Clamp a Q2.30 total to the tilt limit.
   function automatic logic signed [dcta_pkg::MUL_A_W-1:0] clamp_total(
      input logic signed [dcta_pkg::MUL_P_W-1:0] v,
      input logic [dcta_pkg::TILT_W-1:0]         t
   );
      logic signed [dcta_pkg::MUL_P_W-1:0] lim;
      logic signed [dcta_pkg::MUL_P_W-1:0] res;
      lim = dcta_pkg::MUL_P_W'({t, {dcta_pkg::LIM_SHIFT{1'b0}}});
      priority if (v > lim) begin
         res = lim;
      end else if (v < -lim) begin
         res = -lim;
      end else begin
         res = v;
      end
      return dcta_pkg::MUL_A_W'(res);
   endfunction

   // Round a scaled product half away from zero down to Q7.8 degrees.
   function automatic logic signed [dcta_pkg::DEG_W-1:0] round_deg(
      input logic signed [dcta_pkg::MUL_P_W-1:0] v
   );
      logic signed [dcta_pkg::MUL_P_W-1:0] bias;
      logic signed [dcta_pkg::MUL_P_W-1:0] s;
      bias = v[dcta_pkg::MUL_P_W-1] ? (dcta_pkg::DEG_HALF - dcta_pkg::MUL_P_W'(1))
                                    : dcta_pkg::DEG_HALF;
      s = v + bias;
      return dcta_pkg::DEG_W'(s >>> dcta_pkg::DEG_SHIFT);
   endfunction

   dcta_pkg::dcta_state_type state_ff, state_in;
   dcta_pkg::dcta_msel_type  mul_sel;

   logic [dcta_pkg::TILT_W-1:0] tilt_ff, tilt_in;
   logic [dcta_pkg::NEAR_W-1:0] near_ff, near_in;

   logic [dcta_pkg::SUM_W-1:0] sum_ff  [dcta_pkg::COLUMNS];
   logic [dcta_pkg::SUM_W-1:0] sum_in  [dcta_pkg::COLUMNS];
   logic [dcta_pkg::HIT_W-1:0] hits_ff [dcta_pkg::COLUMNS];
   logic [dcta_pkg::HIT_W-1:0] hits_in [dcta_pkg::COLUMNS];

   logic [dcta_pkg::COL_W-1:0] pos_ff, pos_in;
   logic [dcta_pkg::ROW_W-1:0] row_ff, row_in;
   logic [dcta_pkg::COL_W-1:0] col_ff, col_in;

   logic signed [dcta_pkg::ACC_W-1:0] cos_acc_ff, cos_acc_in;
   logic signed [dcta_pkg::ACC_W-1:0] sin_acc_ff, sin_acc_in;
   logic signed [dcta_pkg::DEG_W-1:0] pitch_ff, pitch_in;
   logic signed [dcta_pkg::DEG_W-1:0] roll_ff, roll_in;

   logic signed [dcta_pkg::MUL_A_W-1:0] mul_a;
   logic signed [dcta_pkg::MUL_B_W-1:0] mul_b;
   logic signed [dcta_pkg::MUL_P_W-1:0] mul_prod;

   logic                       req_fire;
   logic                       rsp_fire;
   logic                       csr_write;
   logic                       sample_ok;
   logic                       col_near;
   logic [dcta_pkg::THR_W-1:0] col_limit;
   logic                       scan_done;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_fire  = rsp_chan.valid && rsp_chan.ready;
   assign csr_write = psel && penable && pwrite && pready;
   assign sample_ok = !req_chan.distance[dcta_pkg::DIST_W-1] && (req_chan.distance != '0);
   assign scan_done = (col_ff == dcta_pkg::COL_W'(dcta_pkg::COLUMNS - 1));

   // A column is near when it has two or more hits and its average is below threshold.
   assign col_limit = dcta_pkg::THR_W'(near_ff) * dcta_pkg::THR_W'(hits_ff[col_ff]);
   assign col_near  = (hits_ff[col_ff] > dcta_pkg::HIT_W'(1)) &&
                      (dcta_pkg::THR_W'(sum_ff[col_ff]) < col_limit);

   // Configuration registers.
   assign pready = 1'b1;

   always_comb begin
      tilt_in = tilt_ff;
      near_in = near_ff;
      if (csr_write) begin
         unique case (paddr[2])
            dcta_pkg::REG_TILT: tilt_in = pwdata[dcta_pkg::TILT_W-1:0];
            dcta_pkg::REG_NEAR: near_in = pwdata[dcta_pkg::NEAR_W-1:0];
            default:            tilt_in = tilt_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         dcta_pkg::REG_TILT: prdata = dcta_pkg::CSR_DATA_W'(tilt_ff);
         dcta_pkg::REG_NEAR: prdata = dcta_pkg::CSR_DATA_W'(near_ff);
         default:            prdata = '0;
      endcase
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dcta_pkg::S_IDLE: begin
            if (req_fire && req_chan.last) begin
               state_in = dcta_pkg::S_SCAN;
            end
         end
         dcta_pkg::S_SCAN: begin
            if (scan_done) begin
               state_in = dcta_pkg::S_PMUL;
            end
         end
         dcta_pkg::S_PMUL:  state_in = dcta_pkg::S_PDEG;
         dcta_pkg::S_PDEG:  state_in = dcta_pkg::S_RMUL;
         dcta_pkg::S_RMUL:  state_in = dcta_pkg::S_RDEG;
         dcta_pkg::S_RDEG:  state_in = dcta_pkg::S_ROUND;
         dcta_pkg::S_ROUND: state_in = dcta_pkg::S_OUT;
         dcta_pkg::S_OUT: begin
            if (rsp_fire) begin
               state_in = dcta_pkg::S_IDLE;
            end
         end
         default: state_in = dcta_pkg::S_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and multiplier operand selection.
   always_comb begin
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      mul_sel        = dcta_pkg::M_COS;
      unique case (state_ff)
         dcta_pkg::S_IDLE:  req_chan.ready = 1'b1;
         dcta_pkg::S_PMUL:  mul_sel = dcta_pkg::M_COS;
         dcta_pkg::S_PDEG:  mul_sel = dcta_pkg::M_DEG;
         dcta_pkg::S_RMUL:  mul_sel = dcta_pkg::M_SIN;
         dcta_pkg::S_RDEG:  mul_sel = dcta_pkg::M_DEG;
         dcta_pkg::S_OUT:   rsp_chan.valid = 1'b1;
         default:           mul_sel = dcta_pkg::M_COS;
      endcase
   end

   // Shared multiplier: total times tilt limit, then clamped total times 180/pi.
   always_comb begin
      unique case (mul_sel)
         dcta_pkg::M_COS: begin
            mul_a = dcta_pkg::MUL_A_W'(cos_acc_ff);
            mul_b = dcta_pkg::MUL_B_W'(tilt_ff);
         end
         dcta_pkg::M_SIN: begin
            mul_a = dcta_pkg::MUL_A_W'(sin_acc_ff);
            mul_b = dcta_pkg::MUL_B_W'(tilt_ff);
         end
         dcta_pkg::M_DEG: begin
            mul_a = clamp_total(mul_prod, tilt_ff);
            mul_b = dcta_pkg::RAD2DEG;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   dcta_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   // Column accumulation, scan and result capture.
   always_comb begin
      sum_in     = sum_ff;
      hits_in    = hits_ff;
      pos_in     = pos_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      cos_acc_in = cos_acc_ff;
      sin_acc_in = sin_acc_ff;
      pitch_in   = pitch_ff;
      roll_in    = roll_ff;

      // Each accepted beat with a positive distance adds to its column while inside the counted rows.
      if (req_fire) begin
         if ((row_ff < dcta_pkg::ROW_W'(dcta_pkg::ROWS)) && sample_ok) begin
            sum_in[pos_ff]  = sum_ff[pos_ff] +
                              dcta_pkg::SUM_W'(req_chan.distance[dcta_pkg::DIST_W-2:0]);
            hits_in[pos_ff] = hits_ff[pos_ff] + dcta_pkg::HIT_W'(1);
         end
         if (pos_ff == dcta_pkg::COL_W'(dcta_pkg::COLUMNS - 1)) begin
            pos_in = '0;
            if (row_ff < dcta_pkg::ROW_W'(dcta_pkg::ROWS)) begin
               row_in = row_ff + dcta_pkg::ROW_W'(1);
            end
         end else begin
            pos_in = pos_ff + dcta_pkg::COL_W'(1);
         end
         if (req_chan.last) begin
            col_in     = '0;
            cos_acc_in = '0;
            sin_acc_in = '0;
         end
      end

      // One column per cycle: add its direction when it holds a near obstacle.
      if (state_ff == dcta_pkg::S_SCAN) begin
         if (col_near) begin
            cos_acc_in = cos_acc_ff + dcta_pkg::ACC_W'(dcta_pkg::ROM_COS[col_ff]);
            sin_acc_in = sin_acc_ff + dcta_pkg::ACC_W'(dcta_pkg::ROM_SIN[col_ff]);
         end
         col_in = col_ff + dcta_pkg::COL_W'(1);
      end

      // Degree products come back in the cycle after they are issued.
      if (state_ff == dcta_pkg::S_RMUL) begin
         pitch_in = round_deg(mul_prod);
      end
      if (state_ff == dcta_pkg::S_ROUND) begin
         roll_in = round_deg(mul_prod);
      end

      // The frame is finished once its result beat is taken.
      if (rsp_fire) begin
         for (int i = 0; i < dcta_pkg::COLUMNS; i++) begin
            sum_in[i]  = '0;
            hits_in[i] = '0;
         end
         pos_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dcta_pkg::S_IDLE;
         tilt_ff  <= dcta_pkg::TILT_W'(3277);
         near_ff  <= dcta_pkg::NEAR_W'(512);
         for (int i = 0; i < dcta_pkg::COLUMNS; i++) begin
            sum_ff[i]  <= '0;
            hits_ff[i] <= '0;
         end
         pos_ff <= '0;
         row_ff <= '0;
      end else begin
         state_ff <= state_in;
         tilt_ff  <= tilt_in;
         near_ff  <= near_in;
         sum_ff   <= sum_in;
         hits_ff  <= hits_in;
         pos_ff   <= pos_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff     <= col_in;
      cos_acc_ff <= cos_acc_in;
      sin_acc_ff <= sin_acc_in;
      pitch_ff   <= pitch_in;
      roll_ff    <= roll_in;
   end

   assign rsp_chan.pitch_deg = pitch_ff;
   assign rsp_chan.roll_deg  = roll_ff;

   // Input is never taken while a result beat is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("sample accepted while a result is pending");

   // A frame-end beat starts the scan at the first column.
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.last) |=> (state_ff == dcta_pkg::S_SCAN) && (col_ff == '0))
      else $error("column scan did not start after the frame-end beat");

   // Handing over a result restarts the frame position.
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |=> (pos_ff == '0) && (row_ff == '0) && req_chan.ready)
      else $error("frame position not cleared after the result beat");

endmodule

// ----- dv/depth_column_tilt_avoider_test.sv -----
`timescale 1ns / 1ps

module depth_column_tilt_avoider_test;

   // Fixed-point constants of the column direction table and the degree scaling.
   localparam longint Q30_ONE     = 64'sd1073741824;
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint CENTER_E7   = 64'sd34415926;
   localparam longint HALF_FOV_E7 = 64'sd31410000;
   localparam longint FOV_E7      = 64'sd62820000;
   localparam longint E7          = 64'sd10000000;
   localparam longint DEG_PER_RAD = 64'sd3754936;
   localparam longint Q38_ONE     = 64'sd274877906944;
   localparam int     CYCLE_LIMIT = 400000;
   localparam int     SETTLE      = dcta_pkg::COLUMNS + 10;

   typedef struct packed {
      logic signed [dcta_pkg::DIST_W-1:0] distance;
      logic                               last;
   } depth_sample_type;

   typedef struct packed {
      logic signed [dcta_pkg::DEG_W-1:0] pitch_deg;
      logic signed [dcta_pkg::DEG_W-1:0] roll_deg;
   } tilt_ref_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel, penable, pwrite, pready;
   logic [dcta_pkg::CSR_ADDR_W-1:0] paddr;
   logic [dcta_pkg::CSR_DATA_W-1:0] pwdata, prdata;

   dcta_req_if req_if ();
   dcta_rsp_if rsp_if ();

   depth_column_tilt_avoider u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Predictor state: register copies, direction table and per-column statistics.
   int unsigned tilt_cfg = 3277;
   int unsigned near_cfg = 512;
   logic signed [dcta_pkg::TRIG_W-1:0] dir_cos [dcta_pkg::COLUMNS];
   logic signed [dcta_pkg::TRIG_W-1:0] dir_sin [dcta_pkg::COLUMNS];
   int unsigned col_sum [dcta_pkg::COLUMNS];
   int unsigned col_hits [dcta_pkg::COLUMNS];
   int unsigned depth_col = 0;
   int unsigned depth_row = 0;

   depth_sample_type sample_q [$];
   tilt_ref_type     tilt_ref_q [$];
   tilt_ref_type     seen_ref;
   int               sender_idle_pct = 0;
   int               receiver_stall_pct = 0;
   int               error_count = 0;
   int               cycle_count = 0;

   always #2 clock = ~clock;

   function automatic longint div_round(input longint n, input longint d);
      if (n >= 0)
         return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Cosine and sine in Q30 by truncating Taylor series, folded into +-pi/2.
   function automatic void trig_q30(input longint ang, output longint c, output longint s);
      longint a, a2, term, acc;
      bit     flip;
      a = ang;
      flip = 1'b0;
      while (a > PI_Q30) a -= 2 * PI_Q30;
      while (a < -PI_Q30) a += 2 * PI_Q30;
      if (a > HALF_PI_Q30) begin
         a -= PI_Q30;
         flip = 1'b1;
      end else if (a < -HALF_PI_Q30) begin
         a += PI_Q30;
         flip = 1'b1;
      end
      a2 = a * a / Q30_ONE;
      term = Q30_ONE;
      acc = term;
      for (int k = 1; k <= 8; k++) begin
         term = -(term * a2 / Q30_ONE) / ((2 * k - 1) * (2 * k));
         acc += term;
      end
      c = flip ? -acc : acc;
      term = a;
      acc = a;
      for (int k = 1; k <= 8; k++) begin
         term = -(term * a2 / Q30_ONE) / ((2 * k) * (2 * k + 1));
         acc += term;
      end
      s = flip ? -acc : acc;
   endfunction

   // Clamp a Q2.30 total to the tilt limit and convert to Q7.8 degrees.
   function automatic logic signed [dcta_pkg::DEG_W-1:0] to_degrees(input longint total,
                                                                    input longint limit);
      longint v;
      v = clamp(total, -limit, limit);
      v = div_round(v * DEG_PER_RAD, Q38_ONE);
      v = clamp(v, -32768, 32767);
      return dcta_pkg::DEG_W'(v);
   endfunction

   function automatic void clear_frame();
      for (int x = 0; x < dcta_pkg::COLUMNS; x++) begin
         col_sum[x] = 0;
         col_hits[x] = 0;
      end
      depth_col = 0;
      depth_row = 0;
   endfunction

   // Fold one accepted sample into the column statistics; on the frame end,
   // select the near columns and queue the tilt reference they produce.
   function automatic void accumulate_sample(input logic signed [dcta_pkg::DIST_W-1:0] depth,
                                             input logic last);
      longint       pitch_total, roll_total, limit;
      tilt_ref_type ref_out;
      pitch_total = 0;
      roll_total = 0;
      if (depth_row < dcta_pkg::ROWS && depth_col < dcta_pkg::COLUMNS && depth > 0) begin
         col_sum[depth_col] += unsigned'(int'(depth));
         col_hits[depth_col]++;
      end
      depth_col++;
      if (depth_col >= dcta_pkg::COLUMNS) begin
         depth_col = 0;
         if (depth_row < dcta_pkg::ROWS)
            depth_row++;
      end
      if (!last)
         return;
      for (int x = 0; x < dcta_pkg::COLUMNS; x++) begin
         if (col_hits[x] > 1 && longint'(col_sum[x]) < longint'(near_cfg) * col_hits[x]) begin
            pitch_total += longint'(dir_cos[x]) * longint'(tilt_cfg);
            roll_total += longint'(dir_sin[x]) * longint'(tilt_cfg);
         end
      end
      limit = longint'(tilt_cfg) * 32768;
      ref_out.pitch_deg = to_degrees(pitch_total, limit);
      ref_out.roll_deg = to_degrees(roll_total, limit);
      tilt_ref_q.push_back(ref_out);
      clear_frame();
   endfunction

   // Direction table: angle formed exactly, scaled to Q30, rounded to Q1.15.
   initial begin : direction_table
      longint num, ang, c, s;
      for (int x = 0; x < dcta_pkg::COLUMNS; x++) begin
         num = (CENTER_E7 - HALF_FOV_E7) * dcta_pkg::COLUMNS - FOV_E7 * x;
         ang = num * Q30_ONE / (E7 * dcta_pkg::COLUMNS);
         trig_q30(ang, c, s);
         dir_cos[x] = dcta_pkg::TRIG_W'(clamp(div_round(c, 32768), -32768, 32767));
         dir_sin[x] = dcta_pkg::TRIG_W'(clamp(div_round(s, 32768), -32768, 32767));
      end
      clear_frame();
   end

   // One sample beat of stimulus.
   function automatic void push_sample(input logic signed [dcta_pkg::DIST_W-1:0] depth,
                                       input logic last);
      depth_sample_type item;
      item.distance = depth;
      item.last = last;
      sample_q.push_back(item);
   endfunction

   // Sample value: mostly near or far relative to the threshold, plus invalid
   // and full-range values.
   function automatic logic signed [dcta_pkg::DIST_W-1:0] pick_distance(input bit near_col,
                                                                       input int unsigned thr);
      int unsigned roll, bound;
      roll = $urandom_range(99);
      if (roll < 12)
         return dcta_pkg::DIST_W'(-int'($urandom_range(32768)));
      if (roll < 22)
         return dcta_pkg::DIST_W'($urandom);
      bound = (thr < 1) ? 1 : ((thr > 32767) ? 32767 : thr);
      if (near_col)
         return dcta_pkg::DIST_W'($urandom_range(bound, 1));
      return dcta_pkg::DIST_W'($urandom_range(32767, bound));
   endfunction

   // Random frame: usually full, sometimes short or running past the counted rows.
   function automatic int push_frame();
      int                          len, roll;
      logic [dcta_pkg::COLUMNS-1:0] near_mask;
      roll = $urandom_range(99);
      if (roll < 60)
         len = dcta_pkg::ROWS * dcta_pkg::COLUMNS;
      else if (roll < 75)
         len = $urandom_range(dcta_pkg::ROWS * dcta_pkg::COLUMNS + 16,
                              dcta_pkg::ROWS * dcta_pkg::COLUMNS + 1);
      else
         len = $urandom_range(dcta_pkg::ROWS * dcta_pkg::COLUMNS - 1, 1);
      near_mask = dcta_pkg::COLUMNS'($urandom);
      for (int i = 0; i < len; i++)
         push_sample(pick_distance(near_mask[i % dcta_pkg::COLUMNS], near_cfg), i == len - 1);
      return len;
   endfunction

   // Register write: setup beat, then access beat until pready.
   task automatic write_csr(input logic reg_idx, input logic [dcta_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (reg_idx == dcta_pkg::REG_TILT)
         tilt_cfg = value[dcta_pkg::TILT_W-1:0];
      else
         near_cfg = value[dcta_pkg::NEAR_W-1:0];
   endtask

   // Wait until every queued sample is taken and every reference has arrived,
   // then let the block finish any frame-end pass. The check runs between
   // clock edges so that a beat offered at an edge is already visible.
   task automatic drain();
      while (sample_q.size() != 0 || req_if.valid || tilt_ref_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      sender_idle_pct = (mode == 1) ? 52 : ((mode == 3) ? 11 : 0);
      receiver_stall_pct = (mode == 2) ? 52 : ((mode == 3) ? 11 : 0);
   endtask

   // Sample driver: predicts each accepted beat and offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            accumulate_sample(req_if.distance, req_if.last);
         if (!req_if.valid || req_if.ready) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_if.valid <= 1'b1;
               req_if.distance <= sample_q[0].distance;
               req_if.last <= sample_q[0].last;
               sample_q.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compares each accepted beat with the oldest expected reference.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
         if (rsp_if.valid && rsp_if.ready) begin
            if (tilt_ref_q.size() == 0) begin
               $display("%0t: unexpected result pitch %0d roll %0d", $realtime,
                        rsp_if.pitch_deg, rsp_if.roll_deg);
               error_count++;
            end else begin
               seen_ref = tilt_ref_q.pop_front();
               if (rsp_if.pitch_deg !== seen_ref.pitch_deg) begin
                  $display("%0t: pitch_deg expected %0d actual %0d", $realtime,
                           seen_ref.pitch_deg, rsp_if.pitch_deg);
                  error_count++;
               end
               if (rsp_if.roll_deg !== seen_ref.roll_deg) begin
                  $display("%0t: roll_deg expected %0d actual %0d", $realtime,
                           seen_ref.roll_deg, rsp_if.roll_deg);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned tilt_val, near_val;
      int          count;
      req_if.valid = 1'b0;
      req_if.distance = '0;
      req_if.last = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: a lone sample frame, then columns on both sides of the
      // threshold with invalid samples and an average exactly at the threshold.
      push_sample(16'sd32767, 1'b1);
      push_sample(16'sd1, 1'b0);
      push_sample(16'sd1, 1'b0);
      push_sample(16'sd32767, 1'b0);
      push_sample(-16'sd32768, 1'b0);
      push_sample(16'sd0, 1'b0);
      push_sample(16'sd511, 1'b0);
      push_sample(16'sd2, 1'b0);
      push_sample(16'sd511, 1'b0);
      push_sample(16'sd32767, 1'b0);
      push_sample(-16'sd1, 1'b0);
      push_sample(16'sd0, 1'b0);
      push_sample(16'sd513, 1'b1);
      drain();

      // Largest tilt and threshold: two selected columns drive the total past the limit.
      write_csr(dcta_pkg::REG_TILT, 32'd32767);
      write_csr(dcta_pkg::REG_NEAR, 32'd65535);
      for (int i = 0; i < dcta_pkg::COLUMNS + 2; i++)
         push_sample(16'sd300, i == dcta_pkg::COLUMNS + 1);
      drain();

      // Zero tilt and zero threshold.
      write_csr(dcta_pkg::REG_TILT, 32'd0);
      write_csr(dcta_pkg::REG_NEAR, 32'd0);
      push_sample(-16'sd32768, 1'b0);
      push_sample(16'sd32767, 1'b1);
      drain();

      // Random frames under a range of settings and idling patterns.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin tilt_val = 3277;  near_val = 512;   end
            1: begin tilt_val = 32767; near_val = 65535; end
            2: begin tilt_val = 0;     near_val = 3000;  end
            3: begin tilt_val = 1;     near_val = 100;   end
            4: begin tilt_val = $urandom_range(32767); near_val = $urandom_range(65535); end
            5: begin tilt_val = 32767; near_val = 4000;  end
            6: begin tilt_val = $urandom_range(32767); near_val = $urandom_range(20000); end
            default: begin tilt_val = 16384; near_val = 65535; end
         endcase
         write_csr(dcta_pkg::REG_TILT, tilt_val);
         write_csr(dcta_pkg::REG_NEAR, near_val);
         set_idling(phase % 4);
         count = 0;
         while (count < 106)
            count += push_frame();
         drain();
      end

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
